// ===== sv/sstf_pkg.sv =====
// shared types and constants of the shortest-seek-first disk scheduler
package sstf_pkg;

    // table size and cylinder resolution
    localparam int MAX_REQUESTS = 64;
    localparam int CYL_BITS     = 10;

    // derived widths
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    // fixed widths of the stream fields
    localparam int FCYL_W   = 10;
    localparam int FDIST_W  = 10;
    localparam int SUM_W    = 16;

    // stream packing
    localparam int S_FIELDS_W = 2 * FCYL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = FCYL_W + FDIST_W + SUM_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef logic [CYL_BITS-1:0] cyl_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SUM_W-1:0]    sum_t;
    typedef logic [FCYL_W-1:0]   fcyl_t;
    typedef logic [FDIST_W-1:0]  fdist_t;
    typedef logic [M_PAD_W-1:0]  mpad_t;

    // transaction kinds on the input stream
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_EMIT  = 4'b0100,
        S_EMPTY = 4'b1000
    } state_t;

endpackage

// ===== sv/sstf_disk_scheduler.sv =====
// shortest-seek-first disk request scheduler with its request table memory
//
// Load transactions (tuser = 0) write one cylinder into the request table, one per
// cycle; loads beyond MAX_REQUESTS entries are dropped and reported through load_dropped
// on the next run. A run transaction (tuser = 1) sets the head and serves every stored
// request, nearest first and lowest table index on a tie, one result per service.
// Each service sweeps the table through the single read port of the request memory,
// so a run with n stored requests makes n sweeps over all n entries, plus any time
// the output stage stalls. An empty run returns one result with served low. No input
// is taken while a run is in progress; the fill count and the drop flag are cleared
// when the last result is queued, and each load stores its entry with the served flag
// low.
module sstf_disk_scheduler
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cylinder, head_position
    input  logic [sstf_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // served_cylinder, seek_distance, total_movement, load_dropped
    output logic [sstf_pkg::M_TDATA_W-1:0] m_tdata,
    // served
    output logic                           m_tuser,
    // last_of_run
    output logic                           m_tlast
);

    // request table memory, each entry holds the served flag above the cylinder
    logic [sstf_pkg::CYL_BITS:0] req_mem [sstf_pkg::MAX_REQUESTS];
    logic [sstf_pkg::CYL_BITS:0] rd_data_reg;
    logic                        mem_we;
    sstf_pkg::idx_t              mem_waddr;
    logic [sstf_pkg::CYL_BITS:0] mem_wdata;
    sstf_pkg::idx_t              mem_raddr;
    sstf_pkg::cyl_t              rd_cyl;
    logic                        rd_served;
    logic                        load_we;
    logic                        svc_we;

    // control state
    sstf_pkg::state_t                  state_reg, state_next;
    sstf_pkg::cnt_t                    count_reg, count_next;
    logic                              overflow_reg, overflow_next;
    sstf_pkg::cnt_t                    serv_cnt_reg, serv_cnt_next;
    sstf_pkg::cnt_t                    issue_reg, issue_next;
    logic                              pend_valid_reg, pend_valid_next;
    sstf_pkg::idx_t                    pend_idx_reg, pend_idx_next;
    logic                              found_reg, found_next;
    sstf_pkg::idx_t                    best_idx_reg, best_idx_next;
    sstf_pkg::cyl_t                    best_cyl_reg, best_cyl_next;
    sstf_pkg::cyl_t                    best_dist_reg, best_dist_next;
    sstf_pkg::cyl_t                    head_reg, head_next;
    sstf_pkg::sum_t                    sum_reg, sum_next;

    // output stage
    logic                              m_tvalid_reg, m_tvalid_next;
    logic                              m_served_reg, m_served_next;
    sstf_pkg::fcyl_t                   m_cyl_reg, m_cyl_next;
    sstf_pkg::fdist_t                  m_dist_reg, m_dist_next;
    sstf_pkg::sum_t                    m_total_reg, m_total_next;
    logic                              m_last_reg, m_last_next;
    logic                              m_dropped_reg, m_dropped_next;

    // datapath helpers
    logic           s_fire;
    logic           out_free;
    sstf_pkg::cyl_t in_cyl;
    sstf_pkg::cyl_t in_head;
    sstf_pkg::cyl_t cand_dist;
    logic           cand_ok;
    logic           take;
    logic           last_svc;
    sstf_pkg::sum_t new_sum;
    logic           table_full;

    assign s_tready = (state_reg == sstf_pkg::S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_cyl  = sstf_pkg::cyl_t'(s_tdata[sstf_pkg::FCYL_W-1:0]);
    assign in_head = sstf_pkg::cyl_t'(s_tdata[2*sstf_pkg::FCYL_W-1:sstf_pkg::FCYL_W]);

    assign table_full = (count_reg == sstf_pkg::cnt_t'(sstf_pkg::MAX_REQUESTS));

    // memory ports: loads write at the fill count, a service marks its entry,
    // the sweep reads in order
    assign load_we   = s_fire && (s_tuser == sstf_pkg::REQ_LOAD) && !table_full;
    assign svc_we    = (state_reg == sstf_pkg::S_EMIT) && out_free;
    assign mem_we    = load_we || svc_we;
    assign mem_waddr = svc_we ? best_idx_reg : count_reg[sstf_pkg::IDX_W-1:0];
    assign mem_wdata = svc_we ? {1'b1, best_cyl_reg} : {1'b0, in_cyl};
    assign mem_raddr = issue_reg[sstf_pkg::IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            req_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= req_mem[mem_raddr];
    end

    assign rd_cyl    = rd_data_reg[sstf_pkg::CYL_BITS-1:0];
    assign rd_served = rd_data_reg[sstf_pkg::CYL_BITS];

    // distance of the entry just read and nearest-so-far compare
    assign cand_dist = (rd_cyl >= head_reg) ? (rd_cyl - head_reg)
                                            : (head_reg - rd_cyl);
    assign cand_ok   = pend_valid_reg && !rd_served;
    assign take      = cand_ok && (!found_reg || (cand_dist < best_dist_reg));
    assign last_svc  = (serv_cnt_reg == (count_reg - sstf_pkg::cnt_t'(1)));
    assign new_sum   = sum_reg + sstf_pkg::sum_t'(best_dist_reg);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        overflow_next    = overflow_reg;
        serv_cnt_next    = serv_cnt_reg;
        issue_next       = issue_reg;
        pend_valid_next  = 1'b0;
        pend_idx_next    = pend_idx_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_cyl_next    = best_cyl_reg;
        best_dist_next   = best_dist_reg;
        head_next        = head_reg;
        sum_next         = sum_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_served_next    = m_served_reg;
        m_cyl_next       = m_cyl_reg;
        m_dist_next      = m_dist_reg;
        m_total_next     = m_total_reg;
        m_last_next      = m_last_reg;
        m_dropped_next   = m_dropped_reg;

        unique case (state_reg)
            sstf_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tuser == sstf_pkg::REQ_LOAD)
                    begin
                        if (table_full)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + sstf_pkg::cnt_t'(1);
                        end
                    end
                    else
                    begin
                        head_next     = in_head;
                        sum_next      = '0;
                        serv_cnt_next = '0;
                        issue_next    = '0;
                        found_next    = 1'b0;
                        state_next    = (count_reg == '0) ? sstf_pkg::S_EMPTY
                                                          : sstf_pkg::S_SCAN;
                    end
                end
            end

            sstf_pkg::S_SCAN:
            begin
                // issue one read per cycle until all stored entries are out
                if (issue_reg < count_reg)
                begin
                    issue_next      = issue_reg + sstf_pkg::cnt_t'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[sstf_pkg::IDX_W-1:0];
                end
                // strict compare keeps the lowest index on a tie
                if (take)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = pend_idx_reg;
                    best_cyl_next  = rd_cyl;
                    best_dist_next = cand_dist;
                end
                if ((issue_reg == count_reg) && !pend_valid_reg)
                begin
                    state_next = sstf_pkg::S_EMIT;
                end
            end

            sstf_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_served_next  = 1'b1;
                    m_cyl_next     = sstf_pkg::fcyl_t'(best_cyl_reg);
                    m_dist_next    = sstf_pkg::fdist_t'(best_dist_reg);
                    m_total_next   = new_sum;
                    m_last_next    = last_svc;
                    m_dropped_next = overflow_reg;
                    head_next      = best_cyl_reg;
                    sum_next       = new_sum;
                    serv_cnt_next  = serv_cnt_reg + sstf_pkg::cnt_t'(1);
                    if (last_svc)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = sstf_pkg::S_IDLE;
                    end
                    else
                    begin
                        issue_next = '0;
                        found_next = 1'b0;
                        state_next = sstf_pkg::S_SCAN;
                    end
                end
            end

            sstf_pkg::S_EMPTY:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_served_next  = 1'b0;
                    m_cyl_next     = '0;
                    m_dist_next    = '0;
                    m_total_next   = '0;
                    m_last_next    = 1'b1;
                    m_dropped_next = overflow_reg;
                    overflow_next  = 1'b0;
                    state_next     = sstf_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sstf_pkg::S_IDLE;
            end
        endcase
    end

    // control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sstf_pkg::S_IDLE;
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            serv_cnt_reg    <= '0;
            issue_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            found_reg       <= 1'b0;
            head_reg        <= '0;
            sum_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            overflow_reg    <= overflow_next;
            serv_cnt_reg    <= serv_cnt_next;
            issue_reg       <= issue_next;
            pend_valid_reg  <= pend_valid_next;
            found_reg       <= found_next;
            head_reg        <= head_next;
            sum_reg         <= sum_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_cyl_reg  <= best_cyl_next;
        best_dist_reg <= best_dist_next;
        m_served_reg  <= m_served_next;
        m_cyl_reg     <= m_cyl_next;
        m_dist_reg    <= m_dist_next;
        m_total_reg   <= m_total_next;
        m_last_reg    <= m_last_next;
        m_dropped_reg <= m_dropped_next;
    end

    // output stream
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_served_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {sstf_pkg::mpad_t'(0), m_dropped_reg, m_total_reg, m_dist_reg, m_cyl_reg};

`ifndef SYNTH
    // fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sstf_pkg::cnt_t'(sstf_pkg::MAX_REQUESTS))
        else $error("request count above table size");

    // a sweep only runs over a non-empty table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sstf_pkg::S_SCAN) |-> (count_reg != '0))
        else $error("sweep over empty table");

    // a sweep always has an unserved entry left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sstf_pkg::S_SCAN) |-> (serv_cnt_reg < count_reg))
        else $error("sweep with every entry served");

    // the last service leaves an empty table behind
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sstf_pkg::S_EMIT) && out_free && last_svc) |=>
        ((count_reg == '0) && !overflow_reg))
        else $error("table not cleared after run");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking stream bench for the shortest-seek-first disk scheduler
module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int RANDOM_ITEMS = 380;
    localparam int TAIL_CYCLES  = 50;
    localparam int CYL_TOP      = (1 << sstf_pkg::CYL_BITS) - 1;

    // one service as it leaves the block
    typedef struct {
        logic             served;
        sstf_pkg::fcyl_t  cyl;
        sstf_pkg::fdist_t seek;
        sstf_pkg::sum_t   total;
        logic             last;
        logic             dropped;
    } service_t;

    // tracks the request table and head, and queues the services a run must produce
    class seek_scoreboard;
        sstf_pkg::cyl_t req_table [sstf_pkg::MAX_REQUESTS];
        bit             done_mask [sstf_pkg::MAX_REQUESTS];
        int             req_count;
        bit             dropped_flag;
        sstf_pkg::cyl_t head;
        sstf_pkg::sum_t moved;
        service_t       service_q [$];
        int             errors;

        function new();
            req_count    = 0;
            dropped_flag = 1'b0;
            head         = '0;
            moved        = '0;
            errors       = 0;
            foreach (done_mask[i])
                done_mask[i] = 1'b0;
        endfunction

        // accepted input transaction: load into the table or schedule a whole run
        function void note_request(logic kind, sstf_pkg::cyl_t cyl, sstf_pkg::cyl_t start);
            service_t svc;
            int       n;
            int       best;
            int       best_d;
            int       d;
            if (kind == sstf_pkg::REQ_LOAD)
            begin
                if (req_count < sstf_pkg::MAX_REQUESTS)
                begin
                    req_table[req_count] = cyl;
                    done_mask[req_count] = 1'b0;
                    req_count++;
                end
                else
                    dropped_flag = 1'b1;
                return;
            end
            head  = start;
            moved = '0;
            n     = req_count;
            // empty run
            if (n == 0)
            begin
                svc.served  = 1'b0;
                svc.cyl     = '0;
                svc.seek    = '0;
                svc.total   = '0;
                svc.last    = 1'b1;
                svc.dropped = dropped_flag;
                service_q.push_back(svc);
            end
            // nearest unserved request each time, lowest index on a tie
            for (int k = 0; k < n; k++)
            begin
                best   = -1;
                best_d = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (!done_mask[i])
                    begin
                        d = int'(req_table[i]) - int'(head);
                        if (d < 0)
                            d = -d;
                        if (best < 0 || d < best_d)
                        begin
                            best   = i;
                            best_d = d;
                        end
                    end
                end
                done_mask[best] = 1'b1;
                moved           = moved + sstf_pkg::sum_t'(best_d);
                head            = req_table[best];
                svc.served      = 1'b1;
                svc.cyl         = sstf_pkg::fcyl_t'(head);
                svc.seek        = sstf_pkg::fdist_t'(best_d);
                svc.total       = moved;
                svc.last        = (k == n - 1);
                svc.dropped     = dropped_flag;
                service_q.push_back(svc);
            end
            // table is empty again after the run
            req_count    = 0;
            dropped_flag = 1'b0;
            foreach (done_mask[i])
                done_mask[i] = 1'b0;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 50)
                $display("mismatch at %0t: %s", $time, what);
        endtask

        // accepted output transaction against the oldest queued service
        task check_result(logic [sstf_pkg::M_TDATA_W-1:0] data, logic served, logic last);
            service_t         want;
            sstf_pkg::fcyl_t  got_cyl;
            sstf_pkg::fdist_t got_seek;
            sstf_pkg::sum_t   got_total;
            logic             got_drop;
            if (service_q.size() == 0)
            begin
                report_mismatch("result arrived with no service pending");
                return;
            end
            want      = service_q.pop_front();
            got_cyl   = data[sstf_pkg::FCYL_W-1:0];
            got_seek  = data[sstf_pkg::FCYL_W +: sstf_pkg::FDIST_W];
            got_total = data[sstf_pkg::FCYL_W + sstf_pkg::FDIST_W +: sstf_pkg::SUM_W];
            got_drop  = data[sstf_pkg::FCYL_W + sstf_pkg::FDIST_W + sstf_pkg::SUM_W];
            if (served !== want.served)
                report_mismatch($sformatf("served %0b, want %0b", served, want.served));
            if (got_cyl !== want.cyl)
                report_mismatch($sformatf("cylinder %0d, want %0d", got_cyl, want.cyl));
            if (got_seek !== want.seek)
                report_mismatch($sformatf("seek %0d, want %0d", got_seek, want.seek));
            if (got_total !== want.total)
                report_mismatch($sformatf("total %0d, want %0d", got_total, want.total));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            if (got_drop !== want.dropped)
                report_mismatch($sformatf("dropped %0b, want %0b", got_drop, want.dropped));
        endtask
    endclass

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sstf_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sstf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    seek_scoreboard scoreboard;
    int             send_gap_pct = 16;
    int             take_gap_pct = 58;
    int             items_sent   = 0;
    bit             hold_ask     = 1'b0;
    bit             hold_taken   = 1'b0;
    int             hold_left    = 0;
    int unsigned    cycles       = 0;

    sstf_disk_scheduler u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // output side: check accepted results, random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_result(m_tdata, m_tuser, m_tlast);
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= take_gap_pct);
    end

    // cylinder choice: spread over the range, pinned at the ends, or bunched for ties
    function automatic sstf_pkg::cyl_t pick_cyl(int style, sstf_pkg::cyl_t base);
        case (style)
            0:       return $urandom_range(0, 1) ? sstf_pkg::cyl_t'(CYL_TOP)
                                                 : sstf_pkg::cyl_t'(0);
            1:       return base - sstf_pkg::cyl_t'(4)
                            + sstf_pkg::cyl_t'($urandom_range(0, 8));
            default: return sstf_pkg::cyl_t'($urandom);
        endcase
    endfunction

    // offer one input transaction and hold it until taken
    task automatic send_item(logic kind, sstf_pkg::cyl_t cyl, sstf_pkg::cyl_t start);
        if ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(sstf_pkg::S_TDATA_W - sstf_pkg::S_FIELDS_W){1'b0}}, start, cyl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scoreboard.note_request(kind, cyl, start);
        items_sent++;
    endtask

    // stimulus
    initial
    begin
        int             n_loads;
        int             style;
        int             pick;
        int             random_start;
        sstf_pkg::cyl_t base;
        scoreboard = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty runs at both ends of the range
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(CYL_TOP), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(0), sstf_pkg::cyl_t'(CYL_TOP));
        // extremes, zero seek at the head and a duplicate cylinder
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(0), sstf_pkg::cyl_t'(CYL_TOP));
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(CYL_TOP), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(512), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(512), sstf_pkg::cyl_t'(CYL_TOP));
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(0), sstf_pkg::cyl_t'(CYL_TOP));
        // equal distance on both sides, lowest index wins either way round
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(300), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(100), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(0), sstf_pkg::cyl_t'(200));
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(100), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(300), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(0), sstf_pkg::cyl_t'(200));
        // seek across the full range
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(CYL_TOP), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(CYL_TOP), sstf_pkg::cyl_t'(0));
        // zero seek
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(5), sstf_pkg::cyl_t'(0));
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(0), sstf_pkg::cyl_t'(5));
        // alternating bit patterns
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(10'h2AA), sstf_pkg::cyl_t'(10'h155));
        send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'(10'h155), sstf_pkg::cyl_t'(10'h2AA));
        send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'(10'h2AA), sstf_pkg::cyl_t'(10'h155));

        // random batches of loads closed by a run
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (!hold_ask && items_sent - random_start >= RANDOM_ITEMS / 3)
            begin
                // swap the stall rates and back up the output for a long stretch
                send_gap_pct = 58;
                take_gap_pct = 16;
                hold_ask    <= 1'b1;
                repeat (40)
                    send_item(sstf_pkg::REQ_LOAD, sstf_pkg::cyl_t'($urandom),
                              sstf_pkg::cyl_t'($urandom));
                send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'($urandom),
                          sstf_pkg::cyl_t'($urandom));
            end
            if (items_sent - random_start >= 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 5)
                n_loads = sstf_pkg::MAX_REQUESTS + $urandom_range(0, 6);
            else if (pick < 12)
                n_loads = 0;
            else
                n_loads = $urandom_range(1, 12);
            style = $urandom_range(0, 3);
            base  = sstf_pkg::cyl_t'($urandom);
            repeat (n_loads)
                send_item(sstf_pkg::REQ_LOAD, pick_cyl(style, base), sstf_pkg::cyl_t'($urandom));
            send_item(sstf_pkg::REQ_RUN, sstf_pkg::cyl_t'($urandom), pick_cyl(style, base));
        end
        s_tvalid <= 1'b0;

        // drain and settle
        while (scoreboard.service_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (scoreboard.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sstf_pkg.sv
sv/sstf_disk_scheduler.sv
bench/testbench.sv
